FILE: design/rhs_pkg.sv
// Shared types and constants of the counting hash set.
`default_nettype none
package rhs_pkg;

   localparam int HASH_MULT   = 1235789;
   localparam int HOME_MULT   = 4567;
   localparam int LIMIT_BITS  = 12;
   localparam int LIMIT_RESET = 2730;
   localparam int TAG_MAX     = 60;
   localparam int HOME_MAX    = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int REF_BITS    = 20;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   typedef struct packed {
      logic [1:0]          mode;
      logic [TAG_MAX-1:0]  tag;
      logic [HOME_MAX-1:0] home;
   } item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_DEL_NEXT,
      ST_DEL_CHK,
      ST_DEL_PRB,
      ST_DEL_MOVE
   } state_type;

endpackage
`default_nettype wire

FILE: design/rhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rhs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: design/rhs_front.sv
// Front end: hashes accepted items and works out their home slot.
`default_nettype none
module rhs_front #(
   parameter int TW = 44,
   parameter int IW = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [1:0]        mode,
   input  wire logic [63:0]       element_id,
   input  wire logic              queue_full,
   output logic                   stall,
   output logic                   push,
   output rhs_pkg::item_type      item
);

   logic          advance;
   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [1:0]    s1_mode_ff, s2_mode_ff;
   logic [52:0]   s1_plo_ff;
   logic [31:0]   s1_phi_ff;
   logic [TW-1:0] s2_tag_ff;
   logic [52:0]   plo_in;
   logic [31:0]   phi_in;
   logic [63:0]   hash_in;
   logic [IW-1:0] home_in;
   rhs_pkg::item_type s3_item_ff, s3_item_in;

   assign advance = !s3_valid_ff || !queue_full;
   assign stall   = !advance;
   assign push    = s3_valid_ff && !queue_full;
   assign item    = s3_item_ff;

   // split the 64-bit product into two narrow ones
   assign plo_in  = 53'(element_id[31:0]) * 53'(rhs_pkg::HASH_MULT);
   assign phi_in  = element_id[63:32] * 32'(rhs_pkg::HASH_MULT);
   assign hash_in = 64'(s1_plo_ff) + {s1_phi_ff, 32'd0};
   assign home_in = s2_tag_ff[IW-1:0] * IW'(rhs_pkg::HOME_MULT);

   always_comb begin
      s3_item_in      = '0;
      s3_item_in.mode = s2_mode_ff;
      s3_item_in.tag  = rhs_pkg::TAG_MAX'(s2_tag_ff);
      s3_item_in.home = rhs_pkg::HOME_MAX'(home_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mode_ff <= mode;
         s1_plo_ff  <= plo_in;
         s1_phi_ff  <= phi_in;
         s2_mode_ff <= s1_mode_ff;
         s2_tag_ff  <= hash_in[TW-1:0];
         s3_item_ff <= s3_item_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/rhs_queue.sv
// Short queue of classified items between front and back.
`default_nettype none
module rhs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rhs_pkg::item_type push_item,
   input  wire logic              pop,
   output logic                   not_empty,
   output logic                   full,
   output rhs_pkg::item_type      head
);

   rhs_pkg::item_type                slots_ff [rhs_pkg::QUEUE_DEPTH];
   logic [rhs_pkg::QUEUE_AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [rhs_pkg::QUEUE_AW:0]       count_ff;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (rhs_pkg::QUEUE_AW+1)'(rhs_pkg::QUEUE_DEPTH));
   assign head      = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: design/rhs_back.sv
// Back end: probes the slot table, updates counts, re-places clusters.
`default_nettype none
module rhs_back #(
   parameter int SLOTS = 4096,
   parameter int CB    = 20
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire rhs_pkg::item_type               q_item,
   output logic                                 q_pop,
   input  wire logic [rhs_pkg::LIMIT_BITS-1:0]  load_limit,
   output logic                                 clearing,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_present,
   output logic [rhs_pkg::REF_BITS-1:0]         rsp_ref_count,
   output logic [1:0]                           rsp_status
);

   localparam int IW = $clog2(SLOTS);
   localparam int TW = 64 - CB;
   localparam int CW = (IW > rhs_pkg::LIMIT_BITS) ? IW : rhs_pkg::LIMIT_BITS;
   localparam logic [CB-1:0] CMAX = '1;

   rhs_pkg::state_type state_ff, state_in;
   rhs_pkg::item_type  item_ff, item_in;
   logic [IW-1:0] ix_ff, ix_in, j_ff, j_in, p_ff, p_in, clr_ff, clr_in, occ_ff, occ_in;
   logic [63:0]   d_ff, d_in;
   logic          rv_ff, rv_in, rp_ff, rp_in;
   logic [CB-1:0] rc_ff, rc_in;
   logic [1:0]    rs_ff, rs_in;
   logic [31:0]   rc_wide;

   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;

   logic [TW-1:0] e_tag, i_tag, d_tag;
   logic [CB-1:0] e_cnt;
   logic          e_empty, hit, full, d_hit;
   logic [IW-1:0] d_home;
   logic [CW-1:0] lim_w, lim_eff;

   rhs_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign e_tag   = rd_data[63:CB];
   assign e_cnt   = rd_data[CB-1:0];
   assign e_empty = (rd_data == '0);
   assign i_tag   = item_ff.tag[TW-1:0];
   assign hit     = e_empty || (e_tag == i_tag);
   assign d_tag   = d_ff[63:CB];
   assign d_hit   = e_empty || (e_tag == d_tag);
   assign d_home  = rd_data[CB+IW-1:CB] * IW'(rhs_pkg::HOME_MULT);
   assign lim_w   = CW'(load_limit);
   assign lim_eff = (lim_w > CW'(SLOTS - 1)) ? CW'(SLOTS - 1) : lim_w;
   assign full    = (CW'(occ_ff) >= lim_eff);

   assign clearing      = (state_ff == rhs_pkg::ST_CLEAR);
   assign rsp_valid     = rv_ff;
   assign rsp_present   = rp_ff;
   assign rc_wide       = 32'(rc_ff);
   assign rsp_ref_count = rc_wide[rhs_pkg::REF_BITS-1:0];
   assign rsp_status    = rs_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rhs_pkg::ST_CLEAR: begin
            if (clr_ff == IW'(SLOTS - 1)) state_in = rhs_pkg::ST_IDLE;
         end
         rhs_pkg::ST_IDLE: begin
            if (q_valid && !rv_ff) state_in = rhs_pkg::ST_PROBE;
         end
         rhs_pkg::ST_PROBE: begin
            if (hit) begin
               if (item_ff.mode == rhs_pkg::MODE_REMOVE && !e_empty &&
                   e_cnt != CMAX && e_cnt <= CB'(1)) begin
                  state_in = rhs_pkg::ST_DEL_NEXT;
               end else begin
                  state_in = rhs_pkg::ST_IDLE;
               end
            end
         end
         rhs_pkg::ST_DEL_NEXT: state_in = rhs_pkg::ST_DEL_CHK;
         rhs_pkg::ST_DEL_CHK: begin
            state_in = e_empty ? rhs_pkg::ST_IDLE : rhs_pkg::ST_DEL_PRB;
         end
         rhs_pkg::ST_DEL_PRB: begin
            if (d_hit) begin
               state_in = (p_ff == j_ff) ? rhs_pkg::ST_DEL_NEXT : rhs_pkg::ST_DEL_MOVE;
            end
         end
         rhs_pkg::ST_DEL_MOVE: state_in = rhs_pkg::ST_DEL_NEXT;
         default: state_in = rhs_pkg::ST_CLEAR;
      endcase
   end

   // datapath and table port
   always_comb begin
      item_in = item_ff;
      ix_in   = ix_ff;
      j_in    = j_ff;
      p_in    = p_ff;
      d_in    = d_ff;
      clr_in  = clr_ff;
      occ_in  = occ_ff;
      rv_in   = rv_ff && rsp_stall;
      rp_in   = rp_ff;
      rc_in   = rc_ff;
      rs_in   = rs_ff;
      q_pop   = 1'b0;
      wr_en   = 1'b0;
      wr_addr = ix_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = ix_ff;
      case (state_ff)
         rhs_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         rhs_pkg::ST_IDLE: begin
            if (q_valid && !rv_ff) begin
               q_pop   = 1'b1;
               item_in = q_item;
               ix_in   = q_item.home[IW-1:0];
               rd_en   = 1'b1;
               rd_addr = q_item.home[IW-1:0];
            end
         end
         rhs_pkg::ST_PROBE: begin
            if (!hit) begin
               ix_in   = ix_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = ix_ff + 1'b1;
            end else begin
               rv_in = 1'b1;
               rp_in = !e_empty;
               rc_in = e_cnt;
               rs_in = rhs_pkg::STATUS_OK;
               case (item_ff.mode)
                  rhs_pkg::MODE_ADD: begin
                     if (e_empty) begin
                        if (full) begin
                           rp_in = 1'b0;
                           rc_in = '0;
                           rs_in = rhs_pkg::STATUS_FULL;
                        end else begin
                           wr_en   = 1'b1;
                           wr_data = {i_tag, CB'(1)};
                           occ_in  = occ_ff + 1'b1;
                           rp_in   = 1'b1;
                           rc_in   = CB'(1);
                        end
                     end else if (e_cnt == CMAX) begin
                        rs_in = rhs_pkg::STATUS_SAT;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = {i_tag, e_cnt + 1'b1};
                        rc_in   = e_cnt + 1'b1;
                     end
                  end
                  rhs_pkg::MODE_REMOVE: begin
                     if (!e_empty) begin
                        if (e_cnt == CMAX) begin
                           rs_in = rhs_pkg::STATUS_SAT;
                        end else if (e_cnt > CB'(1)) begin
                           wr_en   = 1'b1;
                           wr_data = {i_tag, e_cnt - 1'b1};
                           rc_in   = e_cnt - 1'b1;
                        end else begin
                           // drop the entry, then walk its cluster
                           wr_en  = 1'b1;
                           occ_in = occ_ff - 1'b1;
                           j_in   = ix_ff;
                           rp_in  = 1'b0;
                           rc_in  = '0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         rhs_pkg::ST_DEL_NEXT: begin
            j_in    = j_ff + 1'b1;
            rd_en   = 1'b1;
            rd_addr = j_ff + 1'b1;
         end
         rhs_pkg::ST_DEL_CHK: begin
            if (!e_empty) begin
               d_in    = rd_data;
               p_in    = d_home;
               rd_en   = 1'b1;
               rd_addr = d_home;
            end
         end
         rhs_pkg::ST_DEL_PRB: begin
            if (!d_hit) begin
               p_in    = p_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = p_ff + 1'b1;
            end else if (p_ff != j_ff) begin
               wr_en   = 1'b1;
               wr_addr = p_ff;
               wr_data = d_ff;
            end
         end
         rhs_pkg::ST_DEL_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhs_pkg::ST_CLEAR;
         clr_ff   <= '0;
         occ_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         occ_ff   <= occ_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      ix_ff   <= ix_in;
      j_ff    <= j_in;
      p_ff    <= p_in;
      d_ff    <= d_in;
      rp_ff   <= rp_in;
      rc_ff   <= rc_in;
      rs_ff   <= rs_in;
   end

endmodule
`default_nettype wire

FILE: design/refcounted_hash_set_linear_probe_core.sv
// Top level of the reference-counting hash set with linear probing.
//
//   channel | direction | handshake          | carries
//   req     | in        | req_valid/req_stall| mode, element_id
//   rsp     | out       | rsp_valid/rsp_stall| present, ref_count, status
//   csr     | in        | csr_valid/csr_ready| load_limit
//
// After reset a clearing pass writes every slot to zero, one slot a cycle;
// req_stall stays high until it ends. An item passes through the registered
// stages s1, s2 and s3 of the hashing front end, then the back end probes
// slots from its home slot on; a delete also walks the following cluster
// and re-places its entries. The slot table has a single read and a single
// write port. The queue lets the front keep accepting while the back works
// or rsp stalls, until the queue is full.
// TABLE_SLOTS must be a power of two.
`default_nettype none
module refcounted_hash_set_linear_probe_core #(
   parameter int TABLE_SLOTS = 4096,
   parameter int COUNT_BITS  = 20
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [63:0]                         req_element_id,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_present,
   output logic [19:0]                              rsp_ref_count,
   output logic [1:0]                               rsp_status,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rhs_pkg::LIMIT_BITS-1:0]      csr_load_limit
);

   localparam int IW = $clog2(TABLE_SLOTS);
   localparam int TW = 64 - COUNT_BITS;

   logic                            front_stall, clearing, accept;
   logic                            push, pop, q_full, q_valid;
   rhs_pkg::item_type               push_item, head_item;
   logic [rhs_pkg::LIMIT_BITS-1:0]  limit_ff;

   // hold items off while the front is blocked or the table is clearing
   assign req_stall = front_stall || clearing;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= rhs_pkg::LIMIT_BITS'(rhs_pkg::LIMIT_RESET);
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_load_limit;
      end
   end

   rhs_front #(.TW(TW), .IW(IW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_mode),
      .element_id (req_element_id),
      .queue_full (q_full),
      .stall      (front_stall),
      .push       (push),
      .item       (push_item)
   );

   rhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (q_valid),
      .full      (q_full),
      .head      (head_item)
   );

   rhs_back #(.SLOTS(TABLE_SLOTS), .CB(COUNT_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (head_item),
      .q_pop         (pop),
      .load_limit    (limit_ff),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_present   (rsp_present),
      .rsp_ref_count (rsp_ref_count),
      .rsp_status    (rsp_status)
   );

endmodule
`default_nettype wire
